// File: rtl/rfpwd_pkg.sv
// Package for the RF pulse-width code decoder: sizes, codes, shared types.
package rfpwd_pkg;

   localparam int BUFFER_BYTES = 10;
   localparam int BIT_CNT_W    = $clog2(BUFFER_BYTES * 8 + 1);
   localparam int BYTE_IDX_W   = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

   localparam int DUR_W   = 20;
   localparam int SHORT_W = 16;
   localparam int TOL_W   = 16;
   localparam int MINB_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int STATUS_W  = 2;
   localparam int OUT_IDX_W = 4;
   localparam int OUT_CNT_W = 7;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_TIME  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BITS   = 3'd5;

   typedef struct packed {
      logic [SHORT_W-1:0] short_time;
      logic [SHORT_W-1:0] long_time;
      logic [TOL_W-1:0]   tolerance;
      logic [DUR_W-1:0]   sync_time;
      logic [DUR_W-1:0]   max_wait;
      logic [MINB_W-1:0]  min_bits;
   } cfg_type;

   typedef enum logic [1:0] {
      TOL_NONE,
      TOL_ADD,
      TOL_SUB
   } tol_mode_type;

   typedef struct packed {
      logic [DUR_W-1:0] nominal;
      tol_mode_type     tol_mode;
   } cmp_req_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC_LO,
      ST_SYNC_HI,
      ST_MAXW,
      ST_SHORT_LO,
      ST_SHORT_HI,
      ST_LONG_LO,
      ST_LONG_HI,
      ST_BIT,
      ST_STOP,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/rfpwd_csr.sv
// Configuration register file of the pulse-width code decoder.
module rfpwd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rfpwd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfpwd_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output rfpwd_pkg::cfg_type                 cfg
);
   import rfpwd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SHORT_TIME: cfg_in.short_time = csr_write_data[SHORT_W-1:0];
            CSR_LONG_TIME:  cfg_in.long_time  = csr_write_data[SHORT_W-1:0];
            CSR_TOLERANCE:  cfg_in.tolerance  = csr_write_data[TOL_W-1:0];
            CSR_SYNC_TIME:  cfg_in.sync_time  = csr_write_data[DUR_W-1:0];
            CSR_MAX_WAIT:   cfg_in.max_wait   = csr_write_data[DUR_W-1:0];
            CSR_MIN_BITS:   cfg_in.min_bits   = csr_write_data[MINB_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_time <= SHORT_W'(500);
         cfg_ff.long_time  <= SHORT_W'(1000);
         cfg_ff.tolerance  <= TOL_W'(100);
         cfg_ff.sync_time  <= DUR_W'(11000);
         cfg_ff.max_wait   <= DUR_W'(75000);
         cfg_ff.min_bits   <= MINB_W'(50);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/rfpwd_cmp.sv
// Shared duration compare unit: duration against nominal, optionally +/- tolerance.
module rfpwd_cmp (
   input  logic [rfpwd_pkg::DUR_W-1:0]  duration,
   input  logic [rfpwd_pkg::TOL_W-1:0]  tolerance,
   input  rfpwd_pkg::cmp_req_type       req,
   output rfpwd_pkg::cmp_rsp_type       rsp
);
   import rfpwd_pkg::*;

   localparam int CW = DUR_W + 3;

   logic [CW-1:0] nom_ext;
   logic [CW-1:0] tol_ext;
   logic [CW-1:0] bound;
   logic [CW-1:0] diff;

   assign nom_ext = CW'(req.nominal);
   assign tol_ext = CW'(tolerance);

   always_comb begin
      unique case (req.tol_mode)
         TOL_ADD: bound = nom_ext + tol_ext;
         TOL_SUB: bound = nom_ext - tol_ext;
         default: bound = nom_ext;
      endcase
   end

   assign diff   = CW'(duration) - bound;
   assign rsp.lt = diff[CW-1];
   assign rsp.eq = (diff == '0);

endmodule

// File: rtl/rfpwd_seq.sv
// Frame sequencer: drives the compare unit, holds bit count, code store and result word.
module rfpwd_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  rfpwd_pkg::cfg_type                  cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_pulse_level,
   input  logic [rfpwd_pkg::DUR_W-1:0]         req_pulse_duration,
   output logic [rfpwd_pkg::DUR_W-1:0]         cmp_duration,
   output rfpwd_pkg::cmp_req_type              cmp_req,
   input  rfpwd_pkg::cmp_rsp_type              cmp_rsp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rfpwd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [rfpwd_pkg::OUT_IDX_W-1:0]     rsp_byte_index,
   output logic [7:0]                          rsp_byte_value,
   output logic [rfpwd_pkg::OUT_CNT_W-1:0]     rsp_bit_count,
   output logic                                rsp_last
);
   import rfpwd_pkg::*;

   localparam logic [BIT_CNT_W-1:0] BIT_CAP = BIT_CNT_W'(BUFFER_BYTES * 8);

   state_type state_ff, state_in;

   logic                  in_frame_ff, in_frame_in;
   logic [BIT_CNT_W-1:0]  bits_ff, bits_in;
   logic                  lo_ok_ff, lo_ok_in;
   logic                  win_ff, win_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic [STATUS_W-1:0]   emit_status_ff, emit_status_in;
   logic [BYTE_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [7:0]            store_ff [BUFFER_BYTES];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OUT_IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic [OUT_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  ge, le, gt;
   logic                  win_now;
   logic                  full;
   logic                  out_free;
   logic                  emit_final;
   logic                  load_out;
   logic                  store_we;
   logic [BYTE_IDX_W-1:0] wr_idx;
   logic [7:0]            store_rd;
   logic [7:0]            store_wr;
   logic [BIT_CNT_W-1:0]  bits_m1;
   logic [BYTE_IDX_W-1:0] last_byte;
   logic [2:0]            align_sh;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ge        = !cmp_rsp.lt;
   assign le        = cmp_rsp.lt || cmp_rsp.eq;
   assign gt        = !cmp_rsp.lt && !cmp_rsp.eq;
   assign win_now   = win_ff || (lo_ok_ff && le);
   assign full      = (bits_ff >= BIT_CAP);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmp_duration = dur_ff;

   assign bits_m1    = bits_ff - BIT_CNT_W'(1);
   assign last_byte  = bits_m1[BYTE_IDX_W+2:3];
   assign emit_final = (emit_status_ff != STATUS_OK) || (bits_ff == '0)
                       || (emit_idx_ff == last_byte);
   assign wr_idx     = bits_ff[BYTE_IDX_W+2:3];
   assign align_sh   = 3'd0 - bits_ff[2:0];
   assign store_rd   = store_ff[emit_idx_ff];
   assign store_wr   = (bits_ff[2:0] == 3'd0) ? {7'd0, ge} : {store_ff[wr_idx][6:0], ge};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_frame_ff) begin
                  state_in = ST_MAXW;
               end else if (!req_pulse_level) begin
                  state_in = ST_SYNC_LO;
               end
            end
         end
         ST_SYNC_LO:  state_in = ge ? ST_SYNC_HI : ST_IDLE;
         ST_SYNC_HI:  state_in = ST_IDLE;
         ST_MAXW:     state_in = gt ? ST_IDLE : ST_SHORT_LO;
         ST_SHORT_LO: state_in = ST_SHORT_HI;
         ST_SHORT_HI: state_in = ST_LONG_LO;
         ST_LONG_LO:  state_in = ST_LONG_HI;
         ST_LONG_HI:  state_in = win_now ? ST_BIT : ST_STOP;
         ST_BIT:      state_in = full ? ST_EMIT : ST_IDLE;
         ST_STOP:     state_in = ge ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (out_free && emit_final) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmp_req.nominal  = cfg.sync_time;
      cmp_req.tol_mode = TOL_NONE;
      load_out = 1'b0;
      store_we = 1'b0;
      unique case (state_ff)
         ST_SYNC_LO: cmp_req.tol_mode = TOL_SUB;
         ST_SYNC_HI: cmp_req.tol_mode = TOL_ADD;
         ST_MAXW:    cmp_req.nominal  = cfg.max_wait;
         ST_SHORT_LO: begin
            cmp_req.nominal  = DUR_W'(cfg.short_time);
            cmp_req.tol_mode = TOL_SUB;
         end
         ST_SHORT_HI: begin
            cmp_req.nominal  = DUR_W'(cfg.short_time);
            cmp_req.tol_mode = TOL_ADD;
         end
         ST_LONG_LO: begin
            cmp_req.nominal  = DUR_W'(cfg.long_time);
            cmp_req.tol_mode = TOL_SUB;
         end
         ST_LONG_HI: begin
            cmp_req.nominal  = DUR_W'(cfg.long_time);
            cmp_req.tol_mode = TOL_ADD;
         end
         ST_BIT: begin
            cmp_req.nominal  = DUR_W'(cfg.short_time);
            cmp_req.tol_mode = TOL_ADD;
            store_we = !full;
         end
         ST_STOP:  cmp_req.tol_mode = TOL_SUB;
         ST_EMIT:  load_out = out_free;
         default:  cmp_req.tol_mode = TOL_NONE;
      endcase
   end

   // datapath next values
   always_comb begin
      in_frame_in    = in_frame_ff;
      bits_in        = bits_ff;
      lo_ok_in       = lo_ok_ff;
      win_in         = win_ff;
      dur_in         = dur_ff;
      emit_status_in = emit_status_ff;
      emit_idx_in    = emit_idx_ff;
      if (accept) begin
         dur_in = req_pulse_duration;
      end
      case (state_ff) inside
         ST_SYNC_HI: begin
            if (le) begin
               in_frame_in = 1'b1;
               bits_in     = '0;
            end
         end
         ST_MAXW: begin
            if (gt) begin
               in_frame_in = 1'b0;
            end
            win_in = 1'b0;
         end
         ST_SHORT_LO, ST_LONG_LO: lo_ok_in = ge;
         ST_SHORT_HI, ST_LONG_HI: win_in = win_now;
         ST_BIT: begin
            emit_idx_in = '0;
            if (full) begin
               in_frame_in    = 1'b0;
               emit_status_in = STATUS_TOO_MANY;
            end else begin
               bits_in = bits_ff + BIT_CNT_W'(1);
            end
         end
         ST_STOP: begin
            emit_idx_in = '0;
            if (ge) begin
               in_frame_in = 1'b0;
               emit_status_in = (16'(bits_ff) < 16'(cfg.min_bits)) ? STATUS_TOO_FEW
                                                                   : STATUS_OK;
            end
         end
         ST_EMIT: begin
            if (load_out && !emit_final) begin
               emit_idx_in = emit_idx_ff + BYTE_IDX_W'(1);
            end
         end
         default: begin
            emit_idx_in = emit_idx_ff;
         end
      endcase
   end

   // result word
   always_comb begin
      rsp_valid_in  = load_out || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_out) begin
         rsp_status_in = emit_status_ff;
         rsp_last_in   = emit_final;
         if (emit_status_ff != STATUS_OK || bits_ff == '0) begin
            rsp_idx_in  = '0;
            rsp_byte_in = '0;
            rsp_cnt_in  = '0;
         end else begin
            rsp_idx_in  = OUT_IDX_W'(emit_idx_ff);
            rsp_byte_in = (emit_idx_ff == last_byte) ? (store_rd << align_sh) : store_rd;
            rsp_cnt_in  = OUT_CNT_W'(bits_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_frame_ff  <= 1'b0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ok_ff       <= lo_ok_in;
      win_ff         <= win_in;
      dur_ff         <= dur_in;
      emit_status_ff <= emit_status_in;
      emit_idx_ff    <= emit_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_last_ff    <= rsp_last_in;
      if (store_we) begin
         store_ff[wr_idx] <= store_wr;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_byte_index = rsp_idx_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_bit_count  = rsp_cnt_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: rtl/rf_pulse_width_code_decoder_core.sv
// Top level of the RF pulse-width code decoder.
// Each pulse is checked against the window bounds in turn by the single shared compare unit;
// req_stall holds off new pulses until the current one is done. A stop or overflow pulse
// then emits its result words (up to 10) to the output, which may stall them.
// Reset (synchronous): hunting, bit count zero, registers at their defaults.
module rf_pulse_width_code_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rfpwd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfpwd_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_pulse_level,
   input  logic [rfpwd_pkg::DUR_W-1:0]        req_pulse_duration,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rfpwd_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rfpwd_pkg::OUT_IDX_W-1:0]    rsp_byte_index,
   output logic [7:0]                         rsp_byte_value,
   output logic [rfpwd_pkg::OUT_CNT_W-1:0]    rsp_bit_count,
   output logic                               rsp_last
);
   import rfpwd_pkg::*;

   cfg_type          cfg;
   cmp_req_type      cmp_req;
   cmp_rsp_type      cmp_rsp;
   logic [DUR_W-1:0] cmp_duration;

   rfpwd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rfpwd_cmp u_cmp (
      .duration  (cmp_duration),
      .tolerance (cfg.tolerance),
      .req       (cmp_req),
      .rsp       (cmp_rsp)
   );

   rfpwd_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pulse_level    (req_pulse_level),
      .req_pulse_duration (req_pulse_duration),
      .cmp_duration       (cmp_duration),
      .cmp_req            (cmp_req),
      .cmp_rsp            (cmp_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_bit_count      (rsp_bit_count),
      .rsp_last           (rsp_last)
   );

endmodule
